### sv/gfcf_pkg.sv
// Package for the gated frequency counter filter.
// Holds shared widths, reset values and the control/status structs; no dependencies.
package gfcf_pkg;

   localparam int FILTER_DEPTH_DEF = 8;
   localparam int IN_W             = 16;
   localparam int FREQ_W           = 32;
   localparam int PROD_W           = IN_W + FREQ_W;
   localparam int DIV_CNT_W        = $clog2(PROD_W + 1);
   localparam int REQ_DATA_W       = 2 * IN_W;
   localparam int RSP_DATA_W       = 2 * FREQ_W;
   localparam int RSP_USER_W       = 1;

   localparam logic [FREQ_W-1:0] REF_CLOCK_RESET = 32'd1_000_000;

   // one microcode control word, as seen by the datapath
   typedef struct packed {
      logic accept;
      logic mul;
      logic ram_rd;
      logic div_load_q;
      logic div_load_f;
      logic div_step;
      logic update;
      logic publish;
   } ctl_type;

   // datapath flags tested by the sequencer's conditional jumps
   typedef struct packed {
      logic req_valid;
      logic gate_zero;
      logic div_more;
      logic out_busy;
   } status_type;

endpackage

### sv/gated_frequency_counter_filter.sv
// Gated frequency counter with moving-average filter, microcoded top level.
// Requests are handled one at a time: a new one is accepted only after the last result is
//   published; a zero gate skips the multiply and both divisions and goes straight to publish.
// The shared 1-bit/cycle divider serves both the frequency and the moving-average division.
// Reset: synchronous, active high; clears the filter, rate register (1 MHz) and output.
module gated_frequency_counter_filter #(
   parameter int FILTER_DEPTH = gfcf_pkg::FILTER_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gfcf_pkg::REQ_DATA_W-1:0]  req_tdata,   // pulse_count, gate_ticks
   input  logic                             csr_we,
   input  logic [gfcf_pkg::FREQ_W-1:0]      csr_wdata,   // ref_clock_hz
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gfcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // frequency_hz, filtered_hz
   output logic [gfcf_pkg::RSP_USER_W-1:0]  rsp_tuser    // gate_error
);

   gfcf_pkg::ctl_type    ctl;
   gfcf_pkg::status_type status;

   gfcf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   gfcf_dp #(
      .FILTER_DEPTH (FILTER_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sv/gfcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gfcf_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
// Depends on gfcf_pkg (ctl_type, status_type).
module gfcf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  gfcf_pkg::status_type   status,
   output gfcf_pkg::ctl_type      ctl
);

   typedef enum logic [3:0] {
      STEP_WAIT   = 4'd0,
      STEP_CHECK  = 4'd1,
      STEP_MUL    = 4'd2,
      STEP_QLOAD  = 4'd3,
      STEP_QRUN   = 4'd4,
      STEP_UPDATE = 4'd5,
      STEP_FLOAD  = 4'd6,
      STEP_FRUN   = 4'd7,
      STEP_PUB    = 4'd8
   } step_type;

   typedef enum logic [2:0] {
      COND_NONE      = 3'd0,
      COND_NO_REQ    = 3'd1,
      COND_GATE_ZERO = 3'd2,
      COND_DIV_MORE  = 3'd3,
      COND_OUT_BUSY  = 3'd4
   } cond_type;

   typedef struct packed {
      gfcf_pkg::ctl_type ctl;
      cond_type          cond;
      step_type          target;
   } uword_type;

   function automatic uword_type rom(input step_type step);
      uword_type w;
      w = '{ctl: '0, cond: COND_NONE, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w.ctl.accept = 1'b1;
            w.cond       = COND_NO_REQ;
            w.target     = STEP_WAIT;
         end
         STEP_CHECK: begin
            w.cond   = COND_GATE_ZERO;
            w.target = STEP_PUB;
         end
         STEP_MUL: begin
            w.ctl.mul    = 1'b1;
            w.ctl.ram_rd = 1'b1;
         end
         STEP_QLOAD: begin
            w.ctl.div_load_q = 1'b1;
         end
         STEP_QRUN: begin
            w.ctl.div_step = 1'b1;
            w.cond         = COND_DIV_MORE;
            w.target       = STEP_QRUN;
         end
         STEP_UPDATE: begin
            w.ctl.update = 1'b1;
         end
         STEP_FLOAD: begin
            w.ctl.div_load_f = 1'b1;
         end
         STEP_FRUN: begin
            w.ctl.div_step = 1'b1;
            w.cond         = COND_DIV_MORE;
            w.target       = STEP_FRUN;
         end
         STEP_PUB: begin
            w.ctl.publish = 1'b1;
            w.cond        = COND_OUT_BUSY;
            w.target      = STEP_PUB;
         end
         default: begin
            w.target = STEP_WAIT;
            w.cond   = COND_NONE;
         end
      endcase
      return w;
   endfunction

   step_type  step_ff;
   step_type  step_in;
   uword_type uword;
   logic      take_jump;

   always_comb begin
      uword = rom(step_ff);
      unique case (uword.cond)
         COND_NONE:      take_jump = 1'b0;
         COND_NO_REQ:    take_jump = !status.req_valid;
         COND_GATE_ZERO: take_jump = status.gate_zero;
         COND_DIV_MORE:  take_jump = status.div_more;
         COND_OUT_BUSY:  take_jump = status.out_busy;
         default:        take_jump = 1'b0;
      endcase
      if (take_jump) begin
         step_in = uword.target;
      end else if (step_ff == STEP_PUB) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl = uword.ctl;

endmodule

### sv/gfcf_dp.sv
// Datapath: input/output registers, multiplier, shared restoring divider, filter ring.
// Depends on gfcf_pkg and gfcf_ram.
module gfcf_dp #(
   parameter int FILTER_DEPTH = gfcf_pkg::FILTER_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gfcf_pkg::ctl_type                   ctl,
   output gfcf_pkg::status_type                status,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gfcf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_we,
   input  logic [gfcf_pkg::FREQ_W-1:0]         csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gfcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [gfcf_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int IN_W      = gfcf_pkg::IN_W;
   localparam int FREQ_W    = gfcf_pkg::FREQ_W;
   localparam int PROD_W    = gfcf_pkg::PROD_W;
   localparam int DCNT_W    = gfcf_pkg::DIV_CNT_W;
   localparam int SLOT_W    = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int CNT_W     = $clog2(FILTER_DEPTH + 1);
   localparam int SUM_W     = FREQ_W + $clog2(FILTER_DEPTH);
   localparam int SUM_SHIFT = PROD_W - SUM_W;

   localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(FILTER_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FILTER_DEPTH - 1);

   logic [FREQ_W-1:0]     ref_ff;
   logic [IN_W-1:0]       count_ff, gate_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [IN_W-1:0]       rem_ff, rem_in;
   logic [IN_W-1:0]       dsr_ff, dsr_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [FREQ_W-1:0]     freq_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [gfcf_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_err_ff;

   logic                  req_fire;
   logic                  full;
   logic                  out_busy;
   logic                  do_pub;
   logic [IN_W+1:0]       trial;
   logic                  trial_ge;
   logic [FREQ_W-1:0]     freq_sat;
   logic [FREQ_W-1:0]     old_freq;

   assign req_tready = ctl.accept && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (fill_ff == FILL_FULL);
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign do_pub     = ctl.publish && !out_busy;
   assign freq_sat   = (|quo_ff[PROD_W-1:FREQ_W]) ? '1 : quo_ff[FREQ_W-1:0];

   assign status.req_valid = req_tvalid;
   assign status.gate_zero = (gate_ff == '0);
   assign status.div_more  = (dcnt_ff > DCNT_W'(1));
   assign status.out_busy  = out_busy;

   // one restoring division bit per step
   assign trial    = {1'b0, rem_ff, quo_ff[PROD_W-1]} - {2'b00, dsr_ff};
   assign trial_ge = !trial[IN_W+1];

   gfcf_ram #(
      .WIDTH (FREQ_W),
      .DEPTH (FILTER_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ctl.update),
      .wr_addr (slot_ff),
      .wr_data (freq_sat),
      .rd_en   (ctl.ram_rd),
      .rd_addr (slot_ff),
      .rd_data (old_freq)
   );

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dcnt_in = dcnt_ff;
      if (ctl.div_load_q) begin
         quo_in  = prod_ff;
         rem_in  = '0;
         dsr_in  = gate_ff;
         dcnt_in = DCNT_W'(PROD_W);
      end else if (ctl.div_load_f) begin
         quo_in  = PROD_W'(sum_ff) << SUM_SHIFT;
         rem_in  = '0;
         dsr_in  = IN_W'(fill_ff);
         dcnt_in = DCNT_W'(SUM_W);
      end else if (ctl.div_step) begin
         quo_in  = {quo_ff[PROD_W-2:0], trial_ge};
         rem_in  = trial_ge ? trial[IN_W-1:0] : {rem_ff[IN_W-2:0], quo_ff[PROD_W-1]};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      fill_in = fill_ff;
      slot_in = slot_ff;
      if (ctl.update) begin
         sum_in  = (full ? (sum_ff - SUM_W'(old_freq)) : sum_ff) + SUM_W'(freq_sat);
         fill_in = full ? fill_ff : (fill_ff + CNT_W'(1));
         slot_in = (slot_ff == SLOT_LAST) ? '0 : (slot_ff + SLOT_W'(1));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (do_pub) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= gfcf_pkg::REF_CLOCK_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            ref_ff <= csr_wdata;
         end
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         count_ff <= req_tdata[IN_W-1:0];
         gate_ff  <= req_tdata[2*IN_W-1:IN_W];
      end
      if (ctl.mul) begin
         prod_ff <= PROD_W'(count_ff) * PROD_W'(ref_ff);
      end
      if (ctl.update) begin
         freq_ff <= freq_sat;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (do_pub) begin
         rsp_err_ff  <= status.gate_zero;
         rsp_data_ff <= status.gate_zero ? '0 : {quo_ff[FREQ_W-1:0], freq_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

### sv/gfcf_checker.sv
// Port-level checker for gated_frequency_counter_filter, bound to the top level.
// Depends on gfcf_pkg and the top level's ports.
module gfcf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gfcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [gfcf_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("gate error with nonzero data");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind gated_frequency_counter_filter gfcf_checker u_gfcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### dv/gated_frequency_counter_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for gated_frequency_counter_filter: gated measurements in, frequency
// and moving average out, each compared with a local ring-buffer model.
// Depends on gfcf_pkg and the block's RTL only.
module gated_frequency_counter_filter_tb;

   localparam int IN_W       = gfcf_pkg::IN_W;
   localparam int FREQ_W     = gfcf_pkg::FREQ_W;
   localparam int REQ_DATA_W = gfcf_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = gfcf_pkg::RSP_DATA_W;
   localparam int RSP_USER_W = gfcf_pkg::RSP_USER_W;
   localparam int RING_DEPTH = gfcf_pkg::FILTER_DEPTH_DEF;

   typedef struct packed {
      logic [FREQ_W-1:0] freq_hz;
      logic [FREQ_W-1:0] avg_hz;
      logic              gate_error;
   } reading_type;

   typedef struct {
      bit                is_rate;
      logic [FREQ_W-1:0] rate;
      logic [IN_W-1:0]   pulses;
      logic [IN_W-1:0]   gate;
   } gate_op_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  csr_we = 1'b0;
   logic [FREQ_W-1:0]     csr_wdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   gated_frequency_counter_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // model state
   logic [FREQ_W-1:0] rate_hz = gfcf_pkg::REF_CLOCK_RESET;
   logic [FREQ_W-1:0] freq_ring [RING_DEPTH];
   logic [63:0]       ring_sum = '0;
   int                ring_filled = 0;
   int                ring_slot = 0;

   gate_op_type pending_ops[$];
   reading_type due_readings[$];
   int          mismatch_count = 0;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int          req_gap = 0;
   int          req_quiet = 0;
   int          rsp_stall = 0;
   int          rsp_quiet = 0;

   initial begin
      foreach (freq_ring[i]) freq_ring[i] = '0;
   end

   function automatic reading_type measure_frequency(logic [IN_W-1:0] pulses,
                                                     logic [IN_W-1:0] gate);
      reading_type r;
      logic [63:0] quotient;
      logic [63:0] avg;
      r = '0;
      if (gate == '0) begin
         r.gate_error = 1'b1;
         return r;
      end
      quotient = (64'(pulses) * 64'(rate_hz)) / 64'(gate);
      r.freq_hz = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[FREQ_W-1:0];
      if (ring_filled < RING_DEPTH)
         ring_filled++;
      else
         ring_sum -= 64'(freq_ring[ring_slot]);
      freq_ring[ring_slot] = r.freq_hz;
      ring_sum += 64'(r.freq_hz);
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      avg = ring_sum / 64'(ring_filled);
      r.avg_hz = avg[FREQ_W-1:0];
      return r;
   endfunction

   // mostly short gaps, a few long ones, and runs with none
   function automatic int pick_gap(inout int quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if (roll < 3) quiet = $urandom_range(10, 60);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 4);
      if (roll < 97) return $urandom_range(5, 40);
      return $urandom_range(41, 160);
   endfunction

   task automatic add_measurement(logic [IN_W-1:0] pulses, logic [IN_W-1:0] gate);
      gate_op_type op;
      op = '{is_rate: 1'b0, rate: '0, pulses: pulses, gate: gate};
      pending_ops.push_back(op);
   endtask

   task automatic add_rate(logic [FREQ_W-1:0] rate);
      gate_op_type op;
      op = '{is_rate: 1'b1, rate: rate, pulses: '0, gate: '0};
      pending_ops.push_back(op);
   endtask

   task automatic add_random_measurement();
      logic [IN_W-1:0] pulses;
      logic [IN_W-1:0] gate;
      int              pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) pulses = '0;
      else if (pick == 1) pulses = '1;
      else if (pick < 5) pulses = IN_W'($urandom_range(0, 255));
      else pulses = IN_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 11);
      if (pick == 0) gate = '0;
      else if (pick == 1) gate = 16'd1;
      else if (pick == 2) gate = '1;
      else if (pick < 6) gate = IN_W'($urandom_range(19000, 21000));
      else gate = IN_W'($urandom_range(0, 65535));
      add_measurement(pulses, gate);
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      gate_op_type op;
      logic        nxt_valid;
      logic        nxt_we;
      nxt_valid = req_tvalid && !req_taken;
      nxt_we = 1'b0;
      if (!reset && !nxt_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops[0];
            if (op.is_rate) begin
               if (due_readings.size() == 0) begin
                  nxt_we = 1'b1;
                  csr_wdata <= op.rate;
                  void'(pending_ops.pop_front());
               end
            end else begin
               nxt_valid = 1'b1;
               req_tdata <= {op.gate, op.pulses};
               void'(pending_ops.pop_front());
               req_gap = pick_gap(req_quiet);
            end
         end
      end
      req_tvalid <= nxt_valid;
      csr_we <= nxt_we;
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_taken || $urandom_range(0, 15) == 0) rsp_stall = pick_gap(rsp_quiet);
      end
   end

   task automatic check_field(string name, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // model update and result check
   always @(posedge clock) begin : score
      reading_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      rsp_taken <= rsp_tvalid && rsp_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_readings.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h/%h", $time,
                        rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = due_readings.pop_front();
               check_field("instant_hz", want.freq_hz, rsp_tdata[FREQ_W-1:0]);
               check_field("filtered_hz", want.avg_hz, rsp_tdata[RSP_DATA_W-1:FREQ_W]);
               check_field("gate_error", 32'(want.gate_error), 32'(rsp_tuser[0]));
            end
         end
         if (csr_we) rate_hz = csr_wdata;
         if (req_tvalid && req_tready)
            due_readings.push_back(measure_frequency(req_tdata[IN_W-1:0],
                                                     req_tdata[REQ_DATA_W-1:IN_W]));
      end
   end

   initial begin
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : run
      logic [FREQ_W-1:0] rate;
      // reset rate, empty filter
      add_measurement(16'h0000, 16'h0000);
      add_measurement(16'hFFFF, 16'h0000);
      add_measurement(16'h0000, 16'h0001);
      add_measurement(16'hFFFF, 16'h0001);
      add_measurement(16'hFFFF, 16'hFFFF);
      add_measurement(16'h0001, 16'hFFFF);
      add_measurement(16'd1000, 16'd20000);
      add_measurement(16'hAAAA, 16'h5555);
      add_measurement(16'h5555, 16'hAAAA);
      add_measurement(16'h1234, 16'h0000);
      add_measurement(16'd20000, 16'd20000);
      add_measurement(16'hFFFF, 16'h0001);
      // full-scale rate: saturation and the exact maximum
      add_rate('1);
      add_measurement(16'hFFFF, 16'h0001);
      add_measurement(16'h0001, 16'h0001);
      add_measurement(16'h0002, 16'h0002);
      add_measurement(16'hFFFF, 16'hFFFF);
      add_measurement(16'h0001, 16'h0000);
      // zero rate
      add_rate('0);
      add_measurement(16'hFFFF, 16'h0001);
      add_measurement(16'h8000, 16'h0003);
      // minimum rate
      add_rate(32'd1);
      add_measurement(16'hFFFF, 16'h0001);
      add_measurement(16'hFFFF, 16'h0002);
      add_measurement(16'h0001, 16'h0002);
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: rate = gfcf_pkg::REF_CLOCK_RESET;
            1: rate = '1;
            2: rate = 32'd1;
            3: rate = 32'd32768;
            4: rate = $urandom_range(0, 32'hFFFF_FFFF);
            5: rate = $urandom_range(1, 32'h00FF_FFFF);
            default: rate = $urandom();
         endcase
         add_rate(rate);
         repeat (125) add_random_measurement();
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_tvalid || due_readings.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### gated_frequency_counter_filter.f
sv/gfcf_pkg.sv
sv/gfcf_ram.sv
sv/gfcf_seq.sv
sv/gfcf_dp.sv
sv/gated_frequency_counter_filter.sv
sv/gfcf_checker.sv
dv/gated_frequency_counter_filter_tb.sv
